[hw/rtl/ptb_pkg.sv]
// ptb_pkg: sizes, node record type and helper functions of the palindromic tree builder.
// No dependencies; used by ptb_if.sv and palindromic_tree_builder_top.sv.
package ptb_pkg;

    localparam int MAX_LEN    = 4096;
    localparam int ALPHABET   = 26;
    localparam int NODE_CAP   = MAX_LEN + 2;
    localparam int EDGE_DEPTH = NODE_CAP * ALPHABET;

    localparam int SYM_W   = 5;
    localparam int NODE_W  = 13;
    localparam int POS_W   = 13;
    localparam int CNT_W   = 13;
    localparam int LEN_W   = 14;
    localparam int HIST_AW = $clog2(MAX_LEN);
    localparam int EDGE_AW = $clog2(EDGE_DEPTH);

    localparam logic [NODE_W-1:0] ODD_ROOT  = NODE_W'(0);
    localparam logic [NODE_W-1:0] EVEN_ROOT = NODE_W'(1);
    localparam logic signed [LEN_W-1:0] ODD_LEN = -LEN_W'(1);

    typedef struct packed {
        logic [NODE_W-1:0] len;
        logic [NODE_W-1:0] link;
        logic [CNT_W-1:0]  cnt;
    } node_rec_t;

    function automatic logic [SYM_W-1:0] sym_mod(input logic [SYM_W-1:0] s);
        return (s >= SYM_W'(ALPHABET)) ? s - SYM_W'(ALPHABET) : s;
    endfunction

    function automatic logic [EDGE_AW-1:0] edge_addr(input logic [NODE_W-1:0] n,
                                                     input logic [SYM_W-1:0] c);
        return EDGE_AW'(n) * EDGE_AW'(ALPHABET) + EDGE_AW'(c);
    endfunction

endpackage

[hw/rtl/ptb_if.sv]
// ptb_if: valid/ready channels for symbol words in and result words out.
// Depends on ptb_pkg for field widths.
interface ptb_in_if import ptb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;

    modport source (output valid, output symbol, input ready);
    modport sink   (input valid, input symbol, output ready);
endinterface

interface ptb_out_if import ptb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] suffix_node;
    logic [NODE_W-1:0] suffix_length;
    logic [CNT_W-1:0]  suffix_count;
    logic              created_node;
    logic [NODE_W-1:0] distinct_total;
    logic              overflow;

    modport source (output valid, output suffix_node, output suffix_length,
                    output suffix_count, output created_node, output distinct_total,
                    output overflow, input ready);
    modport sink   (input valid, input suffix_node, input suffix_length,
                    input suffix_count, input created_node, input distinct_total,
                    input overflow, output ready);
endinterface

[hw/rtl/palindromic_tree_builder_top.sv]
// Palindromic tree builder: one symbol word per item, one result word out, one item at a time.
// After reset a pass clears every edge table entry; item.ready stays low meanwhile.
// Per symbol: S_IDLE, then S_WNODE, S_WHIST, maybe S_WCMP per suffix-link node tried, then S_EDGE,
// then S_NNDATA (existing node), nothing (new one-letter node) or a second walk, S_LKEDGE, S_LKNODE
// (longer new node), then S_DONE; overflow goes S_IDLE to S_DONE. S_DONE registers the result word,
// and a stalled one holds off the next symbol. Async active-low reset clears state, counters, out valid.
module palindromic_tree_builder_top import ptb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ptb_in_if.sink    item,
    ptb_out_if.source result
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WNODE  = 4'd2;
    localparam logic [3:0] S_WHIST  = 4'd3;
    localparam logic [3:0] S_WCMP   = 4'd4;
    localparam logic [3:0] S_EDGE   = 4'd5;
    localparam logic [3:0] S_NNDATA = 4'd6;
    localparam logic [3:0] S_LKEDGE = 4'd7;
    localparam logic [3:0] S_LKNODE = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    // memories
    logic [SYM_W-1:0]  hist_mem [0:MAX_LEN-1];
    node_rec_t         node_mem [0:NODE_CAP-1];
    logic [NODE_W-1:0] edge_mem [0:EDGE_DEPTH-1];

    logic [3:0]         state_reg, state_next;
    logic [EDGE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [NODE_W-1:0]  node_total_reg, node_total_next;
    logic [NODE_W-1:0]  last_node_reg, last_node_next;
    logic [NODE_W-1:0]  n_reg, n_next;
    logic [NODE_W-1:0]  cur_reg, cur_next;
    logic [SYM_W-1:0]   c_reg, c_next;
    logic               phase_reg, phase_next;
    logic signed [LEN_W-1:0] len_reg, len_next;
    logic [NODE_W-1:0]  link_reg, link_next;
    logic [NODE_W-1:0]  nn_reg, nn_next;
    logic [NODE_W-1:0]  new_len_reg, new_len_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               created_reg, created_next;
    logic               ovf_reg, ovf_next;

    logic               out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]  out_node_reg, out_node_next;
    logic [NODE_W-1:0]  out_len_reg, out_len_next;
    logic [CNT_W-1:0]   out_cnt_reg, out_cnt_next;
    logic               out_created_reg, out_created_next;
    logic [NODE_W-1:0]  out_total_reg, out_total_next;
    logic               out_ovf_reg, out_ovf_next;

    // memory ports
    logic               hist_we;
    logic [HIST_AW-1:0] hist_rd_addr;
    logic [SYM_W-1:0]   hist_rd_data_reg;
    logic               node_we;
    logic [NODE_W-1:0]  node_wr_addr;
    node_rec_t          node_wr_data;
    logic [NODE_W-1:0]  node_rd_addr;
    node_rec_t          node_rd_data_reg;
    logic [NODE_W-1:0]  node_addr_q_reg;
    logic               edge_we;
    logic [EDGE_AW-1:0] edge_wr_addr;
    logic [NODE_W-1:0]  edge_wr_data;
    logic [EDGE_AW-1:0] edge_rd_addr;
    logic [NODE_W-1:0]  edge_rd_data_reg;

    // node record as seen after root substitution
    logic signed [LEN_W-1:0] node_len_q;
    logic [NODE_W-1:0]       node_link_q;
    logic [CNT_W-1:0]        node_cnt_q;

    logic signed [LEN_W:0]   diff;
    logic signed [LEN_W-1:0] grown_len;
    logic                    walk_done;

    always_comb
    begin
        case (node_addr_q_reg)
            ODD_ROOT:
            begin
                node_len_q  = ODD_LEN;
                node_link_q = ODD_ROOT;
                node_cnt_q  = '0;
            end
            EVEN_ROOT:
            begin
                node_len_q  = '0;
                node_link_q = ODD_ROOT;
                node_cnt_q  = '0;
            end
            default:
            begin
                node_len_q  = $signed({1'b0, node_rd_data_reg.len});
                node_link_q = node_rd_data_reg.link;
                node_cnt_q  = node_rd_data_reg.cnt;
            end
        endcase
    end

    // history index pos-1-len of the char that must match
    assign diff = $signed({2'b00, pos_reg}) - (LEN_W+1)'(1) - $signed({node_len_q[LEN_W-1], node_len_q});
    assign grown_len = len_reg + LEN_W'(2);
    assign edge_rd_addr = edge_addr(n_reg, c_reg);
    assign node_rd_addr = (state_reg == S_WNODE) ? n_reg : edge_rd_data_reg;
    assign hist_rd_addr = diff[HIST_AW-1:0];

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        pos_next         = pos_reg;
        node_total_next  = node_total_reg;
        last_node_next   = last_node_reg;
        n_next           = n_reg;
        cur_next         = cur_reg;
        c_next           = c_reg;
        phase_next       = phase_reg;
        len_next         = len_reg;
        link_next        = link_reg;
        nn_next          = nn_reg;
        new_len_next     = new_len_reg;
        cnt_next         = cnt_reg;
        created_next     = created_reg;
        ovf_next         = ovf_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_node_next    = out_node_reg;
        out_len_next     = out_len_reg;
        out_cnt_next     = out_cnt_reg;
        out_created_next = out_created_reg;
        out_total_next   = out_total_reg;
        out_ovf_next     = out_ovf_reg;
        hist_we          = 1'b0;
        node_we          = 1'b0;
        node_wr_addr     = nn_reg;
        node_wr_data     = '{len: new_len_reg, link: link_reg, cnt: cnt_reg};
        edge_we          = 1'b0;
        edge_wr_addr     = edge_addr(cur_reg, c_reg);
        edge_wr_data     = node_total_reg;
        walk_done        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                edge_we      = 1'b1;
                edge_wr_addr = clr_cnt_reg;
                edge_wr_data = '0;
                clr_cnt_next = clr_cnt_reg + EDGE_AW'(1);
                if (clr_cnt_reg == EDGE_AW'(EDGE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    c_next       = sym_mod(item.symbol);
                    created_next = 1'b0;
                    if (pos_reg == POS_W'(MAX_LEN))
                    begin
                        ovf_next     = 1'b1;
                        nn_next      = '0;
                        new_len_next = '0;
                        cnt_next     = '0;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        hist_we    = 1'b1;
                        ovf_next   = 1'b0;
                        n_next     = last_node_reg;
                        phase_next = 1'b0;
                        state_next = S_WNODE;
                    end
                end
            end
            S_WNODE:
            begin
                state_next = S_WHIST;
            end
            S_WHIST:
            begin
                len_next  = node_len_q;
                link_next = node_link_q;
                if (!node_len_q[LEN_W-1] && !diff[LEN_W])
                begin
                    state_next = S_WCMP;
                end
                else if (n_reg == ODD_ROOT)
                begin
                    walk_done = 1'b1;
                end
                else
                begin
                    n_next     = node_link_q;
                    state_next = S_WNODE;
                end
            end
            S_WCMP:
            begin
                if (hist_rd_data_reg == c_reg || n_reg == ODD_ROOT)
                begin
                    walk_done = 1'b1;
                end
                else
                begin
                    n_next     = link_reg;
                    state_next = S_WNODE;
                end
            end
            S_EDGE:
            begin
                if (edge_rd_data_reg != '0)
                begin
                    nn_next    = edge_rd_data_reg;
                    state_next = S_NNDATA;
                end
                else
                begin
                    nn_next         = node_total_reg;
                    node_total_next = node_total_reg + NODE_W'(1);
                    created_next    = 1'b1;
                    edge_we         = 1'b1;
                    new_len_next    = grown_len[NODE_W-1:0];
                    if (grown_len == LEN_W'(1))
                    begin
                        // single letter: links to the even root
                        node_we      = 1'b1;
                        node_wr_addr = node_total_reg;
                        node_wr_data = '{len: NODE_W'(1), link: EVEN_ROOT, cnt: CNT_W'(1)};
                        cnt_next     = CNT_W'(1);
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        n_next     = link_reg;
                        phase_next = 1'b1;
                        state_next = S_WNODE;
                    end
                end
            end
            S_NNDATA:
            begin
                new_len_next = node_len_q[NODE_W-1:0];
                cnt_next     = node_cnt_q;
                state_next   = S_DONE;
            end
            S_LKEDGE:
            begin
                link_next  = edge_rd_data_reg;
                state_next = S_LKNODE;
            end
            S_LKNODE:
            begin
                node_we      = 1'b1;
                node_wr_data = '{len: new_len_reg, link: link_reg,
                                 cnt: node_cnt_q + CNT_W'(1)};
                cnt_next     = node_cnt_q + CNT_W'(1);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_node_next    = nn_reg;
                    out_len_next     = new_len_reg;
                    out_cnt_next     = cnt_reg;
                    out_created_next = created_reg;
                    out_total_next   = node_total_reg - NODE_W'(2);
                    out_ovf_next     = ovf_reg;
                    if (!ovf_reg)
                    begin
                        last_node_next = nn_reg;
                        pos_next       = pos_reg + POS_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (walk_done)
        begin
            // edge read at n_reg is already under way; data lands next cycle
            if (phase_reg)
            begin
                state_next = S_LKEDGE;
            end
            else
            begin
                cur_next   = n_reg;
                state_next = S_EDGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_cnt_reg    <= '0;
            pos_reg        <= '0;
            node_total_reg <= NODE_W'(2);
            last_node_reg  <= EVEN_ROOT;
            phase_reg      <= 1'b0;
            created_reg    <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pos_reg        <= pos_next;
            node_total_reg <= node_total_next;
            last_node_reg  <= last_node_next;
            phase_reg      <= phase_next;
            created_reg    <= created_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg           <= n_next;
        cur_reg         <= cur_next;
        c_reg           <= c_next;
        len_reg         <= len_next;
        link_reg        <= link_next;
        nn_reg          <= nn_next;
        new_len_reg     <= new_len_next;
        cnt_reg         <= cnt_next;
        out_node_reg    <= out_node_next;
        out_len_reg     <= out_len_next;
        out_cnt_reg     <= out_cnt_next;
        out_created_reg <= out_created_next;
        out_total_reg   <= out_total_next;
        out_ovf_reg     <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[pos_reg[HIST_AW-1:0]] <= sym_mod(item.symbol);
        end
        hist_rd_data_reg <= hist_mem[hist_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wr_addr] <= node_wr_data;
        end
        node_rd_data_reg <= node_mem[node_rd_addr];
        node_addr_q_reg  <= node_rd_addr;
    end

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_wr_addr] <= edge_wr_data;
        end
        edge_rd_data_reg <= edge_mem[edge_rd_addr];
    end

    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.suffix_node    = out_node_reg;
    assign result.suffix_length  = out_len_reg;
    assign result.suffix_count   = out_cnt_reg;
    assign result.created_node   = out_created_reg;
    assign result.distinct_total = out_total_reg;
    assign result.overflow       = out_ovf_reg;

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !item.ready)
        else $error("symbol accepted during edge table clear");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("second symbol accepted while one is in flight");

    a_new_node_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE && edge_rd_data_reg == '0)
            |=> (node_total_reg == $past(node_total_reg) + NODE_W'(1)))
        else $error("node created without bumping node count");

    a_overflow_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ovf_reg) |-> (out_node_reg == '0 && !out_created_reg))
        else $error("overflow word carries a node");

endmodule
